FILE: hw/rtl/rrbs_pkg.sv
package rrbs_pkg;

	localparam int MARK_W   = 7;
	localparam int COUNT_W  = 40;
	localparam int ITEM_W   = 64;
	localparam int CFG_W    = 40;

	// config register indexes
	localparam logic CFG_MARK_LIMIT  = 1'b0;
	localparam logic CFG_NODE_BUDGET = 1'b1;

	localparam logic [MARK_W-1:0]  MARK_LIMIT_RST  = 7'd111;
	localparam logic [COUNT_W-1:0] NODE_BUDGET_RST = 40'd1000000000;

	typedef logic [MARK_W-1:0]  mark_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		logic [ITEM_W-1:0] allowed_high;
		logic [ITEM_W-1:0] allowed_low;
	} in_item_t;

	typedef struct packed {
		logic   row_found;
		logic   budget_hit;
		mark_t  mark_one;
		mark_t  mark_two;
		mark_t  mark_three;
		mark_t  mark_four;
		mark_t  mark_five;
		count_t node_count;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic init;
		logic count;
		logic seed;
		logic pick;
		logic back;
		logic step;
		logic place;
		logic finish;
		logic found;
		logic stopped;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic budget_hit;
		logic full;
		logic cand_ok;
		logic depth_one;
		logic chk_bad;
		logic chk_last;
	} status_t;

endpackage

FILE: hw/rtl/rrbs_ctrl.sv
module rrbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rrbs_pkg::status_t st,
	output rrbs_pkg::cmd_t    cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ENTER = 2'd1;
	localparam logic [1:0] S_PICK  = 2'd2;
	localparam logic [1:0] S_CHECK = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.init  = 1'b1;
					state_nxt = S_ENTER;
				end
			end
			S_ENTER: begin
				if (st.budget_hit) begin
					cmd.finish  = 1'b1;
					cmd.stopped = 1'b1;
					state_nxt   = S_IDLE;
				end else begin
					cmd.count = 1'b1;
					if (st.full) begin
						cmd.finish = 1'b1;
						cmd.found  = 1'b1;
						state_nxt  = S_IDLE;
					end else begin
						cmd.seed  = 1'b1;
						state_nxt = S_PICK;
					end
				end
			end
			S_PICK: begin
				if (st.cand_ok) begin
					cmd.pick  = 1'b1;
					state_nxt = S_CHECK;
				end else begin
					cmd.back = 1'b1;
					if (st.depth_one) begin
						// tree exhausted
						cmd.finish = 1'b1;
						state_nxt  = S_IDLE;
					end
				end
			end
			S_CHECK: begin
				if (st.chk_bad) begin
					state_nxt = S_PICK;
				end else if (st.chk_last) begin
					cmd.place = 1'b1;
					state_nxt = S_ENTER;
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: hw/rtl/rrbs_dpath.sv
module rrbs_dpath #(
	parameter int MARK_COUNT = 6,
	parameter int MASK_BITS  = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rrbs_pkg::cmd_t      cmd,
	input  rrbs_pkg::in_item_t  item,
	input  rrbs_pkg::mark_t     mark_limit,
	input  rrbs_pkg::count_t    node_budget,
	output rrbs_pkg::status_t   st,
	output logic                done,
	output rrbs_pkg::out_item_t result
);

	localparam int DW  = $clog2(MARK_COUNT + 1);
	localparam int IW  = $clog2(MARK_COUNT);
	localparam int MBW = $clog2(MASK_BITS);
	localparam logic [8:0] MC9 = 9'(MARK_COUNT);
	localparam logic [7:0] MB8 = 8'(MASK_BITS);
	localparam logic [DW-1:0] DEPTH_FULL = DW'(MARK_COUNT);
	localparam logic [DW-1:0] DEPTH_ONE  = DW'(1);

	logic [MASK_BITS-1:0]  allowed_q;
	logic [DW-1:0]         depth_q;
	rrbs_pkg::mark_t       last_q;
	rrbs_pkg::mark_t       cand_q;
	logic [IW-1:0]         j_q;
	logic [MASK_BITS-1:0]  chk_mask_q;
	rrbs_pkg::count_t      visited_q;
	rrbs_pkg::mark_t       mark_q [MARK_COUNT];
	logic [MASK_BITS-1:0]  used_q [MARK_COUNT];
	logic [7:0]            next_q [MARK_COUNT];
	logic                  done_q;
	rrbs_pkg::out_item_t   res_q;

	logic [IW-1:0]         lvl;
	logic [IW-1:0]         lvl_m1;
	logic [DW-1:0]         depth_m1;
	logic [2*rrbs_pkg::ITEM_W-1:0] item_bits;
	rrbs_pkg::mark_t       diff;
	logic [MBW-1:0]        didx;
	logic [MASK_BITS-1:0]  diff_bit;
	logic [8:0]            lhs;
	logic [8:0]            rhs;
	rrbs_pkg::count_t      visited_nxt;
	rrbs_pkg::mark_t       mark_sel [1:5];

	assign depth_m1  = depth_q - DEPTH_ONE;
	assign lvl       = depth_q[IW-1:0];
	assign lvl_m1    = depth_m1[IW-1:0];
	assign item_bits = {item.allowed_high, item.allowed_low};

	// one difference per cycle against mark j
	assign diff = cand_q - mark_q[j_q];
	assign didx = diff[MBW-1:0];

	always_comb begin
		diff_bit       = '0;
		diff_bit[didx] = 1'b1;
	end

	// next <= limit - (MARK_COUNT - d) + 1, kept unsigned
	assign lhs = 9'(next_q[lvl]) + MC9;
	assign rhs = 9'(mark_limit) + 9'd1 + 9'(depth_q);

	assign st.budget_hit = (visited_q >= node_budget);
	assign st.full       = (depth_q == DEPTH_FULL);
	assign st.cand_ok    = (lhs <= rhs);
	assign st.depth_one  = (depth_q == DEPTH_ONE);
	assign st.chk_bad    = ({1'b0, diff} >= MB8) || !allowed_q[didx] || chk_mask_q[didx];
	assign st.chk_last   = (j_q == lvl_m1);

	assign visited_nxt = visited_q + rrbs_pkg::COUNT_W'(cmd.count);

	for (genvar k = 1; k <= 5; k++) begin : g_mark
		if (k < MARK_COUNT) begin : g_on
			assign mark_sel[k] = cmd.found ? mark_q[k] : '0;
		end else begin : g_off
			assign mark_sel[k] = '0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			visited_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.init) begin
				depth_q   <= DEPTH_ONE;
				visited_q <= '0;
			end else begin
				visited_q <= visited_nxt;
				if (cmd.place) begin
					depth_q <= depth_q + DEPTH_ONE;
				end else if (cmd.back) begin
					depth_q <= depth_m1;
				end
			end
		end
	end

	// search stacks and working registers
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			allowed_q <= item_bits[MASK_BITS-1:0];
			last_q    <= '0;
			mark_q[0] <= '0;
			used_q[0] <= '0;
		end
		if (cmd.seed) begin
			next_q[lvl] <= {1'b0, last_q} + 8'd1;
		end
		if (cmd.pick) begin
			cand_q      <= next_q[lvl][6:0];
			next_q[lvl] <= next_q[lvl] + 8'd1;
			chk_mask_q  <= used_q[lvl_m1];
			j_q         <= '0;
		end
		if (cmd.step) begin
			chk_mask_q <= chk_mask_q | diff_bit;
			j_q        <= j_q + IW'(1);
		end
		if (cmd.place) begin
			mark_q[lvl] <= cand_q;
			used_q[lvl] <= chk_mask_q | diff_bit;
			last_q      <= cand_q;
		end
		if (cmd.finish) begin
			res_q.row_found  <= cmd.found;
			res_q.budget_hit <= cmd.stopped;
			res_q.mark_one   <= mark_sel[1];
			res_q.mark_two   <= mark_sel[2];
			res_q.mark_three <= mark_sel[3];
			res_q.mark_four  <= mark_sel[4];
			res_q.mark_five  <= mark_sel[5];
			res_q.node_count <= visited_nxt;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

FILE: hw/rtl/ruler_row_backtrack_search_core.sv
// Depth-first search for one ruler row per input beat.
// Input: item (allowed-difference mask, 128 bits) is taken at a clock edge
//   with start high and busy low. busy stays high for the whole search.
// Output: done pulses for exactly one cycle with result valid; the
//   receiver cannot stall, so each result must be taken in that cycle.
// Config: cfg_we/cfg_idx/cfg_data write mark_limit (0) or node_budget (1)
//   at once; write only while busy is low.
// Timing: the start beat is taken at the edge that ends the idle cycle.
//   After that edge the search takes a step per node entered (plus a
//   final entry step when the budget ends the search), per candidate
//   value a pick step plus a step per difference checked against the
//   marks placed so far (at most MARK_COUNT-1), and a step per backtrack.
//   The single difference checker sets the pace. done is registered from
//   the last search step and rises in the cycle after it.
// The next start is accepted in the cycle done is high.
// Reset (arst_n low) returns to idle, drops done and restores
//   mark_limit 111 and node_budget 1000000000.
module ruler_row_backtrack_search_core #(
	parameter int MARK_COUNT = 6,
	parameter int MASK_BITS  = 128
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  rrbs_pkg::in_item_t        item,
	output logic                      done,
	output rrbs_pkg::out_item_t       result,
	input  logic                      cfg_we,
	input  logic                      cfg_idx,
	input  logic [rrbs_pkg::CFG_W-1:0] cfg_data
);

	rrbs_pkg::mark_t   mark_limit_q;
	rrbs_pkg::count_t  node_budget_q;
	rrbs_pkg::cmd_t    cmd;
	rrbs_pkg::status_t st;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_limit_q  <= rrbs_pkg::MARK_LIMIT_RST;
			node_budget_q <= rrbs_pkg::NODE_BUDGET_RST;
		end else if (cfg_we) begin
			if (cfg_idx == rrbs_pkg::CFG_MARK_LIMIT) begin
				mark_limit_q <= cfg_data[rrbs_pkg::MARK_W-1:0];
			end
			if (cfg_idx == rrbs_pkg::CFG_NODE_BUDGET) begin
				node_budget_q <= cfg_data[rrbs_pkg::COUNT_W-1:0];
			end
		end
	end

	// sequencer: enter node / pick candidate / check differences
	rrbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	// stacks, difference checker, node counter, result register
	rrbs_dpath #(
		.MARK_COUNT (MARK_COUNT),
		.MASK_BITS  (MASK_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.item        (item),
		.mark_limit  (mark_limit_q),
		.node_budget (node_budget_q),
		.st          (st),
		.done        (done),
		.result      (result)
	);

endmodule
